>>> hw/rtl/c32c_pkg.sv
package c32c_pkg;

    localparam int NumLanes = 8;
    localparam int ByteW    = 8;
    localparam int CrcW     = 32;
    localparam int DataW    = NumLanes * ByteW;
    localparam int CntW     = 4;
    localparam int LaneIdxW = $clog2(NumLanes);
    localparam int NumMats  = NumLanes + 1;

    localparam logic [CrcW-1:0] CrcPoly = 32'h82F63B78;

    typedef logic [CrcW-1:0][CrcW-1:0] crc_mat_t;
    typedef logic [NumLanes-1:0][CrcW-1:0] lane_vec_t;

    typedef struct packed {
        logic            first;
        logic            last;
        logic [CntW-1:0] cnt;
        logic [CrcW-1:0] start;
    } req_ctl_t;

    // one shift of the reflected crc register with a zero input bit
    function automatic logic [CrcW-1:0] crc_bit_step(input logic [CrcW-1:0] c);
        logic [CrcW-1:0] r;
        r = c >> 1;
        if (c[0]) begin
            r = r ^ CrcPoly;
        end
        return r;
    endfunction

    // matrix that advances the register over n zero bytes, one column per bit
    function automatic crc_mat_t zero_mat(input int n);
        crc_mat_t        m;
        logic [CrcW-1:0] v;
        for (int i = 0; i < CrcW; i++) begin
            v = '0;
            v[i] = 1'b1;
            for (int k = 0; k < ByteW * n; k++) begin
                v = crc_bit_step(v);
            end
            m[i] = v;
        end
        return m;
    endfunction

    function automatic logic [CrcW-1:0] mat_apply(input crc_mat_t m,
                                                  input logic [CrcW-1:0] v);
        logic [CrcW-1:0] r;
        r = '0;
        for (int i = 0; i < CrcW; i++) begin
            if (v[i]) begin
                r = r ^ m[i];
            end
        end
        return r;
    endfunction

    localparam crc_mat_t ZeroMat [0:NumMats-1] = '{
        zero_mat(0), zero_mat(1), zero_mat(2), zero_mat(3), zero_mat(4),
        zero_mat(5), zero_mat(6), zero_mat(7), zero_mat(8)
    };

endpackage

>>> hw/rtl/c32c_lane.sv
module c32c_lane (
    input  logic [c32c_pkg::LaneIdxW-1:0] lane_idx,
    input  logic [c32c_pkg::ByteW-1:0]    lane_byte,
    output logic [c32c_pkg::CrcW-1:0]     lane_part
);
    import c32c_pkg::*;

    logic [CntW-1:0] lane_dist;

    // byte in lane j still passes through the bytes above it and itself
    assign lane_dist = CntW'(NumLanes) - CntW'(lane_idx);
    assign lane_part = mat_apply(ZeroMat[lane_dist], CrcW'(lane_byte));

endmodule

>>> hw/rtl/c32c_merge.sv
module c32c_merge (
    input  c32c_pkg::lane_vec_t        lane_parts,
    output logic [c32c_pkg::CrcW-1:0]  data_part
);
    import c32c_pkg::*;

    always_comb begin
        data_part = '0;
        for (int j = 0; j < NumLanes; j++) begin
            data_part = data_part ^ lane_parts[j];
        end
    end

endmodule

>>> hw/rtl/crc32c_update_engine_core.sv
// partial crc-32c (castagnoli, reflected, no inversion) over up to eight bytes per request
// input channel s_*: one 64-bit word per request, s_byte_count valid low bytes (0 uses
//   none, above 8 uses all), s_first loads s_start_crc in place of the running value
// output channel m_*: one result per request, m_crc_value is the running crc after
//   the word, m_is_last copies s_last
// throughput: one request per clock, sustained while the receiver keeps m_ready high
// path: each request is registered in stage one, then in the output register behind m_valid
// stage one: eight byte lanes fold their byte through a constant matrix and the
//   merge xors them into the data contribution
// stage two: the seed (start value on first, else running crc) is advanced by the byte
//   count in one matrix step and combined with the data part; this is the only feedback loop
// reset: running crc cleared to zero, both stages emptied
// receiver stall: the output register holds, stage one fills, then s_ready drops
module crc32c_update_engine_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [c32c_pkg::DataW-1:0]    s_data_word,
    input  logic [c32c_pkg::CntW-1:0]     s_byte_count,
    input  logic                          s_first,
    input  logic [c32c_pkg::CrcW-1:0]     s_start_crc,
    input  logic                          s_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [c32c_pkg::CrcW-1:0]     m_crc_value,
    output logic                          m_is_last
);
    import c32c_pkg::*;

    logic [CntW-1:0]  cnt_sat;
    logic [CntW-1:0]  pad_bytes;
    logic [DataW-1:0] word_aligned;
    lane_vec_t        lane_parts;
    logic [CrcW-1:0]  data_part;

    logic             s1_valid_reg;
    logic [CrcW-1:0]  s1_data_reg;
    req_ctl_t         s1_ctl_reg;

    logic             m_valid_reg;
    logic [CrcW-1:0]  m_crc_reg;
    logic             m_last_reg;
    logic [CrcW-1:0]  running_crc_reg;
    logic [CrcW-1:0]  running_crc_next;
    logic [CrcW-1:0]  seed;

    logic             adv_out;
    logic             load_s1;
    logic             fire_s2;

    assign adv_out = !m_valid_reg || m_ready;
    assign s_ready = !s1_valid_reg || adv_out;
    assign load_s1 = s_valid && s_ready;
    assign fire_s2 = s1_valid_reg && adv_out;

    // valid bytes moved to the top of the word, preceded by zero bytes
    assign cnt_sat      = (s_byte_count > CntW'(NumLanes)) ? CntW'(NumLanes) : s_byte_count;
    assign pad_bytes    = CntW'(NumLanes) - cnt_sat;
    assign word_aligned = s_data_word << {pad_bytes, 3'b000};

    for (genvar j = 0; j < NumLanes; j++) begin : g_lane
        c32c_lane u_lane (
            .lane_idx  (LaneIdxW'(j)),
            .lane_byte (word_aligned[j*ByteW +: ByteW]),
            .lane_part (lane_parts[j])
        );
    end

    c32c_merge u_merge (
        .lane_parts (lane_parts),
        .data_part  (data_part)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_s1) begin
            s1_data_reg      <= data_part;
            s1_ctl_reg.first <= s_first;
            s1_ctl_reg.last  <= s_last;
            s1_ctl_reg.cnt   <= cnt_sat;
            s1_ctl_reg.start <= s_start_crc;
        end
    end

    assign seed             = s1_ctl_reg.first ? s1_ctl_reg.start : running_crc_reg;
    assign running_crc_next = mat_apply(ZeroMat[s1_ctl_reg.cnt], seed) ^ s1_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg     <= 1'b0;
            running_crc_reg <= '0;
        end else begin
            if (adv_out) begin
                m_valid_reg <= s1_valid_reg;
            end
            if (fire_s2) begin
                running_crc_reg <= running_crc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire_s2) begin
            m_crc_reg  <= running_crc_next;
            m_last_reg <= s1_ctl_reg.last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_crc_value = m_crc_reg;
    assign m_is_last   = m_last_reg;

endmodule
